>>> rtl/ppc_pkg.sv
// Package for the polyline plane clipper: widths, register indexes and sequencer states.
// Has no dependencies. All other rtl files use it through scoped names.
`default_nettype none
package ppc_pkg;
  localparam int CW = 32;
  localparam int NW = 32;
  localparam int DIST_SHIFT = (CW > 18) ? CW - 18 : 0;
  localparam int MUL_AW = CW + 2;
  localparam int MUL_BW = NW + 1;
  localparam int PROD_W = MUL_AW + MUL_BW;
  localparam int DIST_W = CW + 1 + NW - DIST_SHIFT + 2;
  localparam int FRAC_W = 32;
  localparam int Q_W = FRAC_W + 1;
  localparam int DEN_W = DIST_W + 1;
  localparam int REM_W = DIST_W + 2;
  localparam int DIV_CNT_W = $clog2(Q_W + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic signed [DIST_W-1:0] DIST_UNCLIPPED = DIST_W'(64'd1 << (46 - DIST_SHIFT));

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MX, ST_MY, ST_MZ, ST_MACC, ST_DECIDE, ST_SEG_B, ST_SEG_E,
    ST_DIV_GO, ST_DIV_WAIT, ST_LX, ST_LY, ST_LZ, ST_LW, ST_CROSS, ST_EOUT,
    ST_SEG_NEXT, ST_FINISH
  } state_t;
endpackage
`default_nettype wire

>>> rtl/ppc_in_if.sv
// Vertex input channel: valid/ready handshake with the vertex payload.
// Depends on ppc_pkg for the coordinate width.
`default_nettype none
interface ppc_in_if;
  logic valid;
  logic ready;
  logic signed [ppc_pkg::CW-1:0] vertex_x;
  logic signed [ppc_pkg::CW-1:0] vertex_y;
  logic signed [ppc_pkg::CW-1:0] vertex_z;
  logic first_vertex;
  logic last_vertex;
  logic closed_shape;
  modport source(output valid, vertex_x, vertex_y, vertex_z, first_vertex, last_vertex,
                 closed_shape, input ready);
  modport sink(input valid, vertex_x, vertex_y, vertex_z, first_vertex, last_vertex,
               closed_shape, output ready);
endinterface
`default_nettype wire

>>> rtl/ppc_out_if.sv
// Point output channel: valid/ready handshake with the emitted point payload.
// Depends on ppc_pkg for the coordinate width.
`default_nettype none
interface ppc_out_if;
  logic valid;
  logic ready;
  logic signed [ppc_pkg::CW-1:0] out_x;
  logic signed [ppc_pkg::CW-1:0] out_y;
  logic signed [ppc_pkg::CW-1:0] out_z;
  logic is_crossing;
  logic run_end;
  logic item_done;
  modport source(output valid, out_x, out_y, out_z, is_crossing, run_end, item_done,
                 input ready);
  modport sink(input valid, out_x, out_y, out_z, is_crossing, run_end, item_done,
               output ready);
endinterface
`default_nettype wire

>>> rtl/ppc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on ppc_pkg for operand widths.
`default_nettype none
module ppc_mul (
  input  wire logic                                clk,
  input  wire logic signed [ppc_pkg::MUL_AW-1:0]  a,
  input  wire logic signed [ppc_pkg::MUL_BW-1:0]  b,
  output logic signed [ppc_pkg::PROD_W-1:0]       p_r
);
  always_ff @(posedge clk) begin
    p_r <= ppc_pkg::PROD_W'(a) * ppc_pkg::PROD_W'(b);
  end
endmodule
`default_nettype wire

>>> rtl/ppc_div.sv
// Restoring serial divider giving floor(num * 2^32 / den), one quotient bit per cycle.
// Depends on ppc_pkg for widths.
`default_nettype none
module ppc_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [ppc_pkg::DEN_W-1:0]     num,
  input  wire logic [ppc_pkg::DEN_W-1:0]     den,
  output logic                               done_r,
  output logic [ppc_pkg::Q_W-1:0]            q_r
);
  logic [ppc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ppc_pkg::REM_W-1:0]     rem_r, rem_nxt;
  logic [ppc_pkg::DEN_W-1:0]     den_r, den_nxt;
  logic [ppc_pkg::Q_W-1:0]       q_nxt;
  logic                          done_nxt;
  logic                          ge;

  assign ge = rem_r >= ppc_pkg::REM_W'(den_r);

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = ppc_pkg::DIV_CNT_W'(ppc_pkg::Q_W);
      rem_nxt = ppc_pkg::REM_W'(num);
      den_nxt = den;
      q_nxt   = '0;
    end else if (cnt_r != '0) begin
      if (ge) begin
        rem_nxt = (rem_r - ppc_pkg::REM_W'(den_r)) << 1;
      end else begin
        rem_nxt = rem_r << 1;
      end
      q_nxt   = {q_r[ppc_pkg::Q_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == ppc_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end
endmodule
`default_nettype wire

>>> rtl/polyline_plane_clipper.sv
// Polyline plane clipper: clips a 3D polyline, one vertex per transaction, against a plane
// and emits the visible points and plane crossings. Depends on ppc_pkg, the two channel
// interfaces, ppc_mul and ppc_div.
//
// A vertex first computes its distance to the plane. A point is emitted only when the holding
// slot is empty or the output is free, and a segment that crosses the plane also waits on
// the serial divider for the crossing fraction and the interpolation products; a closed final
// vertex may clip two segments. A single multiplier forms the three distance terms and the
// three interpolation products in turn. The input is not ready while a vertex is in work.
`default_nettype none
module polyline_plane_clipper (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  ppc_in_if.sink                                 in_vtx,
  ppc_out_if.source                              out_pt,
  input  wire logic                              cfg_we,
  input  wire logic [ppc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ppc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  localparam int CW = ppc_pkg::CW;
  localparam int DW = ppc_pkg::DIST_W;

  ppc_pkg::state_t state_r, state_nxt;

  logic                 clip_en_r;
  logic signed [CW-1:0] org_x_r, org_y_r, org_z_r;
  logic signed [ppc_pkg::NW-1:0] nrm_x_r, nrm_y_r, nrm_z_r;

  logic signed [CW-1:0] cur_x_r, cur_y_r, cur_z_r, cur_x_nxt, cur_y_nxt, cur_z_nxt;
  logic signed [DW-1:0] cur_d_r, cur_d_nxt, acc_r, acc_nxt;
  logic first_r, last_r, closed_r, first_nxt, last_nxt, closed_nxt;
  logic signed [CW-1:0] prev_x_r, prev_y_r, prev_z_r, prev_x_nxt, prev_y_nxt, prev_z_nxt;
  logic signed [DW-1:0] prev_d_r, prev_d_nxt;
  logic signed [CW-1:0] start_x_r, start_y_r, start_z_r, start_x_nxt, start_y_nxt, start_z_nxt;
  logic signed [DW-1:0] start_d_r, start_d_nxt;
  logic run_open_r, run_open_nxt, have_prev_r, have_prev_nxt;
  logic seg_idx_r, seg_idx_nxt;

  logic signed [CW-1:0] sb_x_r, sb_y_r, sb_z_r, se_x_r, se_y_r, se_z_r;
  logic signed [CW-1:0] sb_x_nxt, sb_y_nxt, sb_z_nxt, se_x_nxt, se_y_nxt, se_z_nxt;
  logic signed [DW-1:0] sb_d_r, se_d_r, sb_d_nxt, se_d_nxt;
  logic signed [CW-1:0] cx_r, cy_r, cz_r, cx_nxt, cy_nxt, cz_nxt;

  logic                 pend_valid_r, pend_valid_nxt;
  logic signed [CW-1:0] pend_x_r, pend_y_r, pend_z_r, pend_x_nxt, pend_y_nxt, pend_z_nxt;
  logic                 pend_cross_r, pend_rend_r, pend_cross_nxt, pend_rend_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [CW-1:0] out_x_r, out_y_r, out_z_r, out_x_nxt, out_y_nxt, out_z_nxt;
  logic                 out_cross_r, out_rend_r, out_done_r;
  logic                 out_cross_nxt, out_rend_nxt, out_done_nxt;

  logic signed [ppc_pkg::MUL_AW-1:0] mul_a;
  logic signed [ppc_pkg::MUL_BW-1:0] mul_b;
  logic signed [ppc_pkg::PROD_W-1:0] mul_p_r;
  logic                              div_start, div_done;
  logic [ppc_pkg::DEN_W-1:0]         div_num, div_den;
  logic [ppc_pkg::Q_W-1:0]           div_q;

  logic in_acc, out_free, emit_ok, bin, ein;
  logic signed [CW:0]   m_diff, op_delta, res_delta;
  logic signed [CW-1:0] m_coord, m_org, op_b, op_e, res_b, res_e, res_val;
  logic signed [ppc_pkg::NW-1:0] m_nrm;
  logic [CW:0]          op_mag;
  logic [ppc_pkg::PROD_W-1:0] lsum;
  logic [CW-1:0]        lr;
  logic signed [DW-1:0] term;
  logic [DW-1:0]        mag_b, mag_e;

  ppc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p_r));

  ppc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done_r(div_done), .q_r(div_q)
  );

  assign in_acc   = in_vtx.valid && in_vtx.ready;
  assign out_free = !out_valid_r || out_pt.ready;
  assign emit_ok  = !pend_valid_r || out_free;
  assign bin      = !sb_d_r[DW-1];
  assign ein      = !se_d_r[DW-1];

  assign mag_b   = sb_d_r[DW-1] ? DW'(-sb_d_r) : DW'(sb_d_r);
  assign mag_e   = se_d_r[DW-1] ? DW'(-se_d_r) : DW'(se_d_r);
  assign div_num = ppc_pkg::DEN_W'(mag_b);
  assign div_den = ppc_pkg::DEN_W'(mag_b) + ppc_pkg::DEN_W'(mag_e);

  // Operand selection for the shared multiplier.
  always_comb begin
    m_coord = cur_x_r;
    m_org   = org_x_r;
    m_nrm   = nrm_x_r;
    op_b    = sb_x_r;
    op_e    = se_x_r;
    case (state_r)
      ppc_pkg::ST_MY: begin
        m_coord = cur_y_r;
        m_org   = org_y_r;
        m_nrm   = nrm_y_r;
      end
      ppc_pkg::ST_MZ: begin
        m_coord = cur_z_r;
        m_org   = org_z_r;
        m_nrm   = nrm_z_r;
      end
      ppc_pkg::ST_LY: begin
        op_b = sb_y_r;
        op_e = se_y_r;
      end
      ppc_pkg::ST_LZ: begin
        op_b = sb_z_r;
        op_e = se_z_r;
      end
      default: begin
      end
    endcase
  end

  assign m_diff   = {m_coord[CW-1], m_coord} - {m_org[CW-1], m_org};
  assign op_delta = {op_e[CW-1], op_e} - {op_b[CW-1], op_b};
  assign op_mag   = op_delta[CW] ? (CW+1)'(-op_delta) : (CW+1)'(op_delta);

  always_comb begin
    if (state_r == ppc_pkg::ST_LX || state_r == ppc_pkg::ST_LY ||
        state_r == ppc_pkg::ST_LZ) begin
      mul_a = {1'b0, op_mag};
      mul_b = {1'b0, div_q[ppc_pkg::FRAC_W-1:0]};
    end else begin
      mul_a = {m_diff[CW], m_diff};
      mul_b = {m_nrm[ppc_pkg::NW-1], m_nrm};
    end
  end

  assign term = mul_p_r[ppc_pkg::DIST_SHIFT +: DW];

  // Interpolation result of the product that arrives this cycle.
  always_comb begin
    res_b = sb_x_r;
    res_e = se_x_r;
    case (state_r)
      ppc_pkg::ST_LZ: begin
        res_b = sb_y_r;
        res_e = se_y_r;
      end
      ppc_pkg::ST_LW: begin
        res_b = sb_z_r;
        res_e = se_z_r;
      end
      default: begin
      end
    endcase
  end

  assign res_delta = {res_e[CW-1], res_e} - {res_b[CW-1], res_b};
  assign lsum      = ppc_pkg::PROD_W'(mul_p_r) +
                     ppc_pkg::PROD_W'(64'd1 << (ppc_pkg::FRAC_W - 1));
  assign lr        = lsum[ppc_pkg::FRAC_W +: CW];
  assign res_val   = div_q[ppc_pkg::Q_W-1] ? res_e :
                     (res_delta[CW] ? res_b - $signed(lr) : res_b + $signed(lr));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppc_pkg::ST_IDLE:   if (in_acc) state_nxt = ppc_pkg::ST_MX;
      ppc_pkg::ST_MX:     state_nxt = ppc_pkg::ST_MY;
      ppc_pkg::ST_MY:     state_nxt = ppc_pkg::ST_MZ;
      ppc_pkg::ST_MZ:     state_nxt = ppc_pkg::ST_MACC;
      ppc_pkg::ST_MACC:   state_nxt = ppc_pkg::ST_DECIDE;
      ppc_pkg::ST_DECIDE: begin
        state_nxt = (first_r || !have_prev_r) ? ppc_pkg::ST_IDLE : ppc_pkg::ST_SEG_B;
      end
      ppc_pkg::ST_SEG_B: begin
        if (!bin && !ein) begin
          state_nxt = ppc_pkg::ST_SEG_NEXT;
        end else if (!run_open_r && bin) begin
          if (emit_ok) state_nxt = ppc_pkg::ST_SEG_E;
        end else begin
          state_nxt = ppc_pkg::ST_SEG_E;
        end
      end
      ppc_pkg::ST_SEG_E: begin
        if (bin && ein) begin
          if (emit_ok) state_nxt = ppc_pkg::ST_SEG_NEXT;
        end else begin
          state_nxt = ppc_pkg::ST_DIV_GO;
        end
      end
      ppc_pkg::ST_DIV_GO:   state_nxt = ppc_pkg::ST_DIV_WAIT;
      ppc_pkg::ST_DIV_WAIT: if (div_done) state_nxt = ppc_pkg::ST_LX;
      ppc_pkg::ST_LX:       state_nxt = ppc_pkg::ST_LY;
      ppc_pkg::ST_LY:       state_nxt = ppc_pkg::ST_LZ;
      ppc_pkg::ST_LZ:       state_nxt = ppc_pkg::ST_LW;
      ppc_pkg::ST_LW:       state_nxt = ppc_pkg::ST_CROSS;
      ppc_pkg::ST_CROSS: begin
        if (emit_ok) state_nxt = bin ? ppc_pkg::ST_SEG_NEXT : ppc_pkg::ST_EOUT;
      end
      ppc_pkg::ST_EOUT:   if (emit_ok) state_nxt = ppc_pkg::ST_SEG_NEXT;
      ppc_pkg::ST_SEG_NEXT: begin
        state_nxt = (!seg_idx_r && last_r && closed_r) ? ppc_pkg::ST_SEG_B :
                                                         ppc_pkg::ST_FINISH;
      end
      ppc_pkg::ST_FINISH: if (!pend_valid_r || out_free) state_nxt = ppc_pkg::ST_IDLE;
      default:            state_nxt = ppc_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output control.
  always_comb begin
    logic                 emit;
    logic signed [CW-1:0] ex, ey, ez;
    logic                 ec, er;
    emit = 1'b0;
    ex = se_x_r;
    ey = se_y_r;
    ez = se_z_r;
    ec = 1'b0;
    er = 1'b0;
    cur_x_nxt = cur_x_r;  cur_y_nxt = cur_y_r;  cur_z_nxt = cur_z_r;  cur_d_nxt = cur_d_r;
    first_nxt = first_r;  last_nxt = last_r;    closed_nxt = closed_r;
    acc_nxt = acc_r;
    prev_x_nxt = prev_x_r;  prev_y_nxt = prev_y_r;  prev_z_nxt = prev_z_r;
    prev_d_nxt = prev_d_r;
    start_x_nxt = start_x_r;  start_y_nxt = start_y_r;  start_z_nxt = start_z_r;
    start_d_nxt = start_d_r;
    run_open_nxt = run_open_r;  have_prev_nxt = have_prev_r;  seg_idx_nxt = seg_idx_r;
    sb_x_nxt = sb_x_r;  sb_y_nxt = sb_y_r;  sb_z_nxt = sb_z_r;  sb_d_nxt = sb_d_r;
    se_x_nxt = se_x_r;  se_y_nxt = se_y_r;  se_z_nxt = se_z_r;  se_d_nxt = se_d_r;
    cx_nxt = cx_r;  cy_nxt = cy_r;  cz_nxt = cz_r;
    pend_valid_nxt = pend_valid_r;
    pend_x_nxt = pend_x_r;  pend_y_nxt = pend_y_r;  pend_z_nxt = pend_z_r;
    pend_cross_nxt = pend_cross_r;  pend_rend_nxt = pend_rend_r;
    out_valid_nxt = out_valid_r && !out_pt.ready;
    out_x_nxt = out_x_r;  out_y_nxt = out_y_r;  out_z_nxt = out_z_r;
    out_cross_nxt = out_cross_r;  out_rend_nxt = out_rend_r;  out_done_nxt = out_done_r;
    div_start = 1'b0;

    case (state_r)
      ppc_pkg::ST_IDLE: begin
        if (in_acc) begin
          cur_x_nxt  = in_vtx.vertex_x;
          cur_y_nxt  = in_vtx.vertex_y;
          cur_z_nxt  = in_vtx.vertex_z;
          first_nxt  = in_vtx.first_vertex;
          last_nxt   = in_vtx.last_vertex;
          closed_nxt = in_vtx.closed_shape;
        end
      end
      ppc_pkg::ST_MY:   acc_nxt = term;
      ppc_pkg::ST_MZ:   acc_nxt = acc_r + term;
      ppc_pkg::ST_MACC: cur_d_nxt = clip_en_r ? acc_r + term : ppc_pkg::DIST_UNCLIPPED;
      ppc_pkg::ST_DECIDE: begin
        if (first_r || !have_prev_r) begin
          start_x_nxt = cur_x_r;
          start_y_nxt = cur_y_r;
          start_z_nxt = cur_z_r;
          start_d_nxt = cur_d_r;
          run_open_nxt  = 1'b0;
          have_prev_nxt = !last_r;
          prev_x_nxt = cur_x_r;
          prev_y_nxt = cur_y_r;
          prev_z_nxt = cur_z_r;
          prev_d_nxt = cur_d_r;
        end else begin
          sb_x_nxt = prev_x_r;  sb_y_nxt = prev_y_r;  sb_z_nxt = prev_z_r;
          sb_d_nxt = prev_d_r;
          se_x_nxt = cur_x_r;   se_y_nxt = cur_y_r;   se_z_nxt = cur_z_r;
          se_d_nxt = cur_d_r;
          seg_idx_nxt = 1'b0;
        end
      end
      ppc_pkg::ST_SEG_B: begin
        if (!bin && !ein) begin
          run_open_nxt = 1'b0;
        end else if (!run_open_r && bin && emit_ok) begin
          emit = 1'b1;
          ex = sb_x_r;
          ey = sb_y_r;
          ez = sb_z_r;
          run_open_nxt = 1'b1;
        end
      end
      ppc_pkg::ST_SEG_E: begin
        if (bin && ein && emit_ok) emit = 1'b1;
      end
      ppc_pkg::ST_DIV_GO: div_start = 1'b1;
      ppc_pkg::ST_LY:     cx_nxt = res_val;
      ppc_pkg::ST_LZ:     cy_nxt = res_val;
      ppc_pkg::ST_LW:     cz_nxt = res_val;
      ppc_pkg::ST_CROSS: begin
        if (emit_ok) begin
          emit = 1'b1;
          ex = cx_r;
          ey = cy_r;
          ez = cz_r;
          ec = 1'b1;
          er = bin;
          run_open_nxt = !bin;
        end
      end
      ppc_pkg::ST_EOUT: begin
        if (emit_ok) begin
          emit = 1'b1;
          run_open_nxt = 1'b1;
        end
      end
      ppc_pkg::ST_SEG_NEXT: begin
        if (!seg_idx_r && last_r && closed_r) begin
          sb_x_nxt = cur_x_r;    sb_y_nxt = cur_y_r;    sb_z_nxt = cur_z_r;
          sb_d_nxt = cur_d_r;
          se_x_nxt = start_x_r;  se_y_nxt = start_y_r;  se_z_nxt = start_z_r;
          se_d_nxt = start_d_r;
          seg_idx_nxt = 1'b1;
        end
      end
      ppc_pkg::ST_FINISH: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_x_nxt = pend_x_r;
            out_y_nxt = pend_y_r;
            out_z_nxt = pend_z_r;
            out_cross_nxt = pend_cross_r;
            out_rend_nxt  = pend_rend_r || (last_r && run_open_r);
            out_done_nxt  = 1'b1;
          end
          pend_valid_nxt = 1'b0;
          if (last_r) begin
            run_open_nxt  = 1'b0;
            have_prev_nxt = 1'b0;
          end
          prev_x_nxt = cur_x_r;
          prev_y_nxt = cur_y_r;
          prev_z_nxt = cur_z_r;
          prev_d_nxt = cur_d_r;
        end
      end
      default: begin
      end
    endcase

    // A new point goes to the holding slot; the one it displaces is not the last.
    if (emit) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_x_nxt = pend_x_r;
        out_y_nxt = pend_y_r;
        out_z_nxt = pend_z_r;
        out_cross_nxt = pend_cross_r;
        out_rend_nxt  = pend_rend_r;
        out_done_nxt  = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_x_nxt = ex;
      pend_y_nxt = ey;
      pend_z_nxt = ez;
      pend_cross_nxt = ec;
      pend_rend_nxt  = er;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ppc_pkg::ST_IDLE;
      clip_en_r    <= 1'b0;
      org_x_r      <= '0;
      org_y_r      <= '0;
      org_z_r      <= '0;
      nrm_x_r      <= '0;
      nrm_y_r      <= '0;
      nrm_z_r      <= ppc_pkg::NW'(32'sd1073741824);
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      prev_z_r     <= '0;
      prev_d_r     <= '0;
      start_x_r    <= '0;
      start_y_r    <= '0;
      start_z_r    <= '0;
      start_d_r    <= '0;
      run_open_r   <= 1'b0;
      have_prev_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      prev_x_r     <= prev_x_nxt;
      prev_y_r     <= prev_y_nxt;
      prev_z_r     <= prev_z_nxt;
      prev_d_r     <= prev_d_nxt;
      start_x_r    <= start_x_nxt;
      start_y_r    <= start_y_nxt;
      start_z_r    <= start_z_nxt;
      start_d_r    <= start_d_nxt;
      run_open_r   <= run_open_nxt;
      have_prev_r  <= have_prev_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ppc_pkg::CFG_CLIP_ENABLE: clip_en_r <= cfg_wdata[0];
          ppc_pkg::CFG_ORIGIN_X:    org_x_r   <= cfg_wdata[CW-1:0];
          ppc_pkg::CFG_ORIGIN_Y:    org_y_r   <= cfg_wdata[CW-1:0];
          ppc_pkg::CFG_ORIGIN_Z:    org_z_r   <= cfg_wdata[CW-1:0];
          ppc_pkg::CFG_NORMAL_X:    nrm_x_r   <= cfg_wdata[ppc_pkg::NW-1:0];
          ppc_pkg::CFG_NORMAL_Y:    nrm_y_r   <= cfg_wdata[ppc_pkg::NW-1:0];
          ppc_pkg::CFG_NORMAL_Z:    nrm_z_r   <= cfg_wdata[ppc_pkg::NW-1:0];
          default: begin
          end
        endcase
      end
    end
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    cur_z_r <= cur_z_nxt;
    cur_d_r <= cur_d_nxt;
    first_r <= first_nxt;
    last_r <= last_nxt;
    closed_r <= closed_nxt;
    acc_r <= acc_nxt;
    seg_idx_r <= seg_idx_nxt;
    sb_x_r <= sb_x_nxt;
    sb_y_r <= sb_y_nxt;
    sb_z_r <= sb_z_nxt;
    sb_d_r <= sb_d_nxt;
    se_x_r <= se_x_nxt;
    se_y_r <= se_y_nxt;
    se_z_r <= se_z_nxt;
    se_d_r <= se_d_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    cz_r <= cz_nxt;
    pend_x_r <= pend_x_nxt;
    pend_y_r <= pend_y_nxt;
    pend_z_r <= pend_z_nxt;
    pend_cross_r <= pend_cross_nxt;
    pend_rend_r <= pend_rend_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
    out_z_r <= out_z_nxt;
    out_cross_r <= out_cross_nxt;
    out_rend_r <= out_rend_nxt;
    out_done_r <= out_done_nxt;
  end

  assign in_vtx.ready       = (state_r == ppc_pkg::ST_IDLE);
  assign out_pt.valid       = out_valid_r;
  assign out_pt.out_x       = out_x_r;
  assign out_pt.out_y       = out_y_r;
  assign out_pt.out_z       = out_z_r;
  assign out_pt.is_crossing = out_cross_r;
  assign out_pt.run_end     = out_rend_r;
  assign out_pt.item_done   = out_done_r;
endmodule
`default_nettype wire

>>> sim/polyline_plane_clipper_test.sv
// Self-checking testbench for polyline_plane_clipper: directed polylines and random ones
// under random idling, with results compared against a behavioral clipper model.
// Depends on ppc_pkg, ppc_in_if, ppc_out_if and the clipper RTL.
`default_nettype none
module polyline_plane_clipper_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 160;
  localparam int TOTAL_VERTICES = 270;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic crossing;
    logic run_end;
    logic done;
  } point_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [ppc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ppc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ppc_in_if in_vtx();
  ppc_out_if out_pt();

  polyline_plane_clipper DUT (
    .clk(clk), .rst_n(rst_n), .in_vtx(in_vtx), .out_pt(out_pt),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  point_t expected_points[$];
  point_t step_points[$];
  int mismatches = 0;
  int vertices_sent = 0;
  int hold_cycles = 0;
  bit steady = 1'b0;
  longint unsigned cycles = 0;

  bit clip_on;
  longint org_x, org_y, org_z, nrm_x, nrm_y, nrm_z;
  longint prv_x, prv_y, prv_z, prv_d, beg_x, beg_y, beg_z, beg_d;
  bit run_live, has_prev;

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint scaled_term(longint diff, longint nrm);
    bit neg;
    longint unsigned dm, nm, hi, lo, q, rem;
    neg = (diff < 0) != (nrm < 0);
    dm = magnitude(diff);
    nm = magnitude(nrm);
    hi = (dm >> 32) * nm;
    lo = (dm & 64'hFFFF_FFFF) * nm;
    q = (hi << (32 - ppc_pkg::DIST_SHIFT)) + (lo >> ppc_pkg::DIST_SHIFT);
    rem = lo & ((64'd1 << ppc_pkg::DIST_SHIFT) - 1);
    if (neg && rem != 0) q = q + 1;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint plane_distance(longint x, longint y, longint z);
    if (!clip_on) return longint'(64'd1 << (46 - ppc_pkg::DIST_SHIFT));
    return scaled_term(x - org_x, nrm_x) + scaled_term(y - org_y, nrm_y)
         + scaled_term(z - org_z, nrm_z);
  endfunction

  function automatic longint unsigned crossing_fraction(longint unsigned num,
                                                        longint unsigned den);
    longint unsigned q, r;
    q = 0;
    r = num;
    for (int i = 0; i < 33; i++) begin
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
      r = r << 1;
    end
    return q;
  endfunction

  function automatic longint lerp_coord(longint b, longint e, longint unsigned t);
    longint delta;
    longint unsigned m, r;
    delta = e - b;
    m = magnitude(delta);
    if (t >= (64'd1 << 32)) return e;
    r = (m >> 32) * t + (((m & 64'hFFFF_FFFF) * t + (64'd1 << 31)) >> 32);
    return (delta < 0) ? b - longint'(r) : b + longint'(r);
  endfunction

  function automatic void add_point(longint x, longint y, longint z, bit crossing, bit rend);
    point_t p;
    p.x = x[31:0];
    p.y = y[31:0];
    p.z = z[31:0];
    p.crossing = crossing;
    p.run_end = rend;
    p.done = 1'b0;
    step_points.push_back(p);
  endfunction

  function automatic void clip_segment(longint bx, longint by, longint bz, longint bd,
                                       longint ex, longint ey, longint ez, longint ed);
    bit b_in, e_in;
    longint unsigned t;
    b_in = bd >= 0;
    e_in = ed >= 0;
    if (!b_in && !e_in) begin
      run_live = 1'b0;
      return;
    end
    if (!run_live && b_in) begin
      add_point(bx, by, bz, 1'b0, 1'b0);
      run_live = 1'b1;
    end
    if (b_in && e_in) begin
      add_point(ex, ey, ez, 1'b0, 1'b0);
      return;
    end
    t = crossing_fraction(magnitude(bd), magnitude(bd) + magnitude(ed));
    if (b_in) begin
      add_point(lerp_coord(bx, ex, t), lerp_coord(by, ey, t), lerp_coord(bz, ez, t),
                1'b1, 1'b1);
      run_live = 1'b0;
    end else begin
      add_point(lerp_coord(bx, ex, t), lerp_coord(by, ey, t), lerp_coord(bz, ez, t),
                1'b1, 1'b0);
      add_point(ex, ey, ez, 1'b0, 1'b0);
      run_live = 1'b1;
    end
  endfunction

  function automatic void predict_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                         bit first, bit last, bit closed);
    longint x, y, z, d;
    x = longint'(signed'(vx));
    y = longint'(signed'(vy));
    z = longint'(signed'(vz));
    d = plane_distance(x, y, z);
    step_points.delete();
    if (first || !has_prev) begin
      beg_x = x; beg_y = y; beg_z = z; beg_d = d;
      run_live = 1'b0;
      has_prev = !last;
    end else begin
      clip_segment(prv_x, prv_y, prv_z, prv_d, x, y, z, d);
      if (last) begin
        if (closed) clip_segment(x, y, z, d, beg_x, beg_y, beg_z, beg_d);
        if (run_live && step_points.size() > 0)
          step_points[step_points.size() - 1].run_end = 1'b1;
        run_live = 1'b0;
        has_prev = 1'b0;
      end
    end
    prv_x = x; prv_y = y; prv_z = z; prv_d = d;
    if (step_points.size() > 0) step_points[step_points.size() - 1].done = 1'b1;
    foreach (step_points[i]) expected_points.push_back(step_points[i]);
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_pt.valid && out_pt.ready) begin
      point_t want;
      if (expected_points.size() == 0) begin
        $display("unexpected point transaction at %0t", $realtime);
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        if (out_pt.out_x !== want.x) report_mismatch("out_x", out_pt.out_x, want.x);
        if (out_pt.out_y !== want.y) report_mismatch("out_y", out_pt.out_y, want.y);
        if (out_pt.out_z !== want.z) report_mismatch("out_z", out_pt.out_z, want.z);
        if (out_pt.is_crossing !== want.crossing)
          report_mismatch("is_crossing", out_pt.is_crossing, want.crossing);
        if (out_pt.run_end !== want.run_end)
          report_mismatch("run_end", out_pt.run_end, want.run_end);
        if (out_pt.item_done !== want.done)
          report_mismatch("item_done", out_pt.item_done, want.done);
      end
    end
  end

  int ready_stall = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pt.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_pt.ready <= 1'b0;
      hold_cycles--;
    end else if (ready_stall > 0) begin
      out_pt.ready <= 1'b0;
      ready_stall--;
    end else if (steady || $urandom_range(0, 99) < 70) begin
      out_pt.ready <= 1'b1;
    end else begin
      out_pt.ready <= 1'b0;
      ready_stall = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("polyline_plane_clipper_test: FAIL");
      $finish;
    end
  end

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             bit first, bit last, bit closed);
    int gap;
    in_vtx.valid <= 1'b1;
    in_vtx.vertex_x <= x;
    in_vtx.vertex_y <= y;
    in_vtx.vertex_z <= z;
    in_vtx.first_vertex <= first;
    in_vtx.last_vertex <= last;
    in_vtx.closed_shape <= closed;
    do @(posedge clk); while (!in_vtx.ready);
    predict_vertex(x, y, z, first, last, closed);
    vertices_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_vtx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_vtx.valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [ppc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      ppc_pkg::CFG_CLIP_ENABLE: clip_on = data[0];
      ppc_pkg::CFG_ORIGIN_X: org_x = longint'(signed'(data));
      ppc_pkg::CFG_ORIGIN_Y: org_y = longint'(signed'(data));
      ppc_pkg::CFG_ORIGIN_Z: org_z = longint'(signed'(data));
      ppc_pkg::CFG_NORMAL_X: nrm_x = longint'(signed'(data));
      ppc_pkg::CFG_NORMAL_Y: nrm_y = longint'(signed'(data));
      ppc_pkg::CFG_NORMAL_Z: nrm_z = longint'(signed'(data));
      default: ;
    endcase
  endtask

  task automatic set_plane(bit enable, logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] nx, logic [31:0] ny, logic [31:0] nz);
    write_reg(ppc_pkg::CFG_CLIP_ENABLE, {31'd0, enable});
    write_reg(ppc_pkg::CFG_ORIGIN_X, ox);
    write_reg(ppc_pkg::CFG_ORIGIN_Y, oy);
    write_reg(ppc_pkg::CFG_ORIGIN_Z, oz);
    write_reg(ppc_pkg::CFG_NORMAL_X, nx);
    write_reg(ppc_pkg::CFG_NORMAL_Y, ny);
    write_reg(ppc_pkg::CFG_NORMAL_Z, nz);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_coord();
    if ($urandom_range(0, 99) < 80) return 32'($urandom_range(0, 32'h0010_0000)) - 32'h8_0000;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_normal();
    return 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
  endfunction

  task automatic test_passthrough();
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1, 0, 0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0);
    send_vertex(32'h0001_0000, 32'h0, 32'h8000_0000, 0, 1, 1);
    send_vertex(32'h1234_5678, 32'h0, 32'h0, 1, 1, 1);
    wait_drained();
  endtask

  task automatic test_directed_clip();
    set_plane(1, 0, 0, 0, 0, 0, 32'h4000_0000);
    @(posedge clk);
    write_reg(3'd7, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    send_vertex(0, 0, 32'h0002_0000, 1, 0, 0);
    send_vertex(32'h0003_0000, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0);
    send_vertex(32'h0005_0000, 0, 32'hFFFE_0000, 0, 0, 0);
    send_vertex(32'h0001_0000, 32'h0004_0000, 0, 0, 0, 0);
    send_vertex(32'h0002_0000, 32'h0002_0000, 32'hFFFF_8000, 0, 1, 1);
    send_vertex(32'h0001_0000, 0, 32'h0001_0000, 0, 0, 0);
    send_vertex(32'h0002_0000, 0, 32'h0001_0000, 0, 0, 0);
    send_vertex(32'h0007_0000, 0, 32'h0003_0000, 1, 0, 0);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 1);
    wait_drained();
    set_plane(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'hC000_0000, 32'h4000_0000, 32'hC000_0000);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
    send_vertex(32'h0, 32'h0, 32'h0, 0, 1, 1);
    wait_drained();
    set_plane(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h4000_0000, 32'hC000_0000, 32'h0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1, 0, 0);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 0, 0, 0);
    send_vertex(32'h0, 32'h0, 32'h0, 0, 1, 1);
    wait_drained();
  endtask

  task automatic random_polyline(bit noisy);
    int len;
    bit closed;
    len = $urandom_range(1, 6);
    closed = $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if (noisy)
        send_vertex(pick_coord(), pick_coord(), pick_coord(), $urandom_range(0, 1),
                    $urandom_range(0, 1), $urandom_range(0, 1));
      else
        send_vertex(pick_coord(), pick_coord(), pick_coord(), i == 0, i == len - 1, closed);
    end
  endtask

  task automatic test_backpressure();
    set_plane(1, 0, 0, 0, 32'h2D41_3CCD, 0, 32'h2D41_3CCD);
    @(posedge clk);
    hold_cycles = 600;
    for (int i = 0; i < 10; i++)
      send_vertex(pick_coord(), pick_coord(), pick_coord(), i == 0, i == 9, 1);
    wait_drained();
  endtask

  task automatic test_random();
    int phase;
    phase = 0;
    while (vertices_sent < TOTAL_VERTICES) begin
      if (phase % 3 == 2)
        set_plane(1, $urandom, $urandom, $urandom, pick_normal(), pick_normal(), pick_normal());
      else
        set_plane(phase % 7 != 6, pick_coord(), pick_coord(), pick_coord(),
                  pick_normal(), pick_normal(), pick_normal());
      steady = (phase % 4 == 1);
      for (int k = 0; k < 8 && vertices_sent < TOTAL_VERTICES; k++)
        random_polyline($urandom_range(0, 9) == 0);
      wait_drained();
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    clip_on = 0; org_x = 0; org_y = 0; org_z = 0;
    nrm_x = 0; nrm_y = 0; nrm_z = 64'd1073741824;
    prv_x = 0; prv_y = 0; prv_z = 0; prv_d = 0;
    beg_x = 0; beg_y = 0; beg_z = 0; beg_d = 0;
    run_live = 0; has_prev = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_vtx.valid <= 1'b0;
    in_vtx.vertex_x <= '0;
    in_vtx.vertex_y <= '0;
    in_vtx.vertex_z <= '0;
    in_vtx.first_vertex <= 1'b0;
    in_vtx.last_vertex <= 1'b0;
    in_vtx.closed_shape <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_passthrough();
    test_directed_clip();
    test_backpressure();
    test_random();
    wait_drained();
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("polyline_plane_clipper_test: PASS");
    end else begin
      $display("polyline_plane_clipper_test: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
rtl/ppc_pkg.sv
rtl/ppc_in_if.sv
rtl/ppc_out_if.sv
rtl/ppc_mul.sv
rtl/ppc_div.sv
rtl/polyline_plane_clipper.sv
sim/polyline_plane_clipper_test.sv
